// ===== rtl/gdds_pkg.sv =====
// shared types and constants for the drift-diffusion stencil core
`timescale 1ns / 1ps
package gdds_pkg;

  localparam int VAL_W  = 16;
  localparam int IN_W   = 32;
  localparam int RES_W  = 32;
  localparam int ROW_W  = 10;
  localparam int COL_W  = 8;
  localparam int PAD_W  = 6;
  localparam int OUT_W  = RES_W + ROW_W + COL_W + PAD_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COLS_W     = 9;
  localparam int ROWS_W     = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_H_SQ      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOUR_H_SQ = 2'd3;

  localparam int TAP_N = 5;
  localparam logic [2:0] TAP_UP  = 3'd0;
  localparam logic [2:0] TAP_DN  = 3'd1;
  localparam logic [2:0] TAP_LF  = 3'd2;
  localparam logic [2:0] TAP_RT  = 3'd3;
  localparam logic [2:0] TAP_MID = 3'd4;

  typedef struct packed {
    logic              ram_we;
    logic              ram_re;
    logic              cap_en;
    logic [2:0]        cap_tap;
    logic              st1_en;
    logic              st2_en;
    logic              st3_en;
    logic              out_load;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
    logic              cell_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/grid_drift_diffusion_stencil_core.sv =====
// top level of the drift-diffusion stencil core
//
//  channel   direction  word                                        handshake
//  s_*       in         tdata: x_value[15:0], y_value[31:16]        tvalid/tready
//  m_*       out        tdata: result_value[31:0], cell_row[41:32], tvalid/tready
//                              cell_col[49:42]; tlast: frame_last
//  cfg_*     in         cfg_index, cfg_data                         cfg_valid/cfg_ready
//
//  an input word is taken only while no result is in progress; each result it releases takes
//  five reads of the single-read-port row store, one drain, three multiply stages and one
//  output load, and a word releases n results with n from 0 to 3
//  synchronous reset clears position and restores config defaults; the row store is not
//  cleared and needs no pass after reset
//  the output register holds a word until m_tready; a new input word is taken meanwhile,
//  and the next result waits in the output stage while the register is still occupied
`timescale 1ns / 1ps
module grid_drift_diffusion_stencil_core #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [gdds_pkg::IN_W-1:0]         s_tdata,   // x_value, y_value
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gdds_pkg::OUT_W-1:0]        m_tdata,   // result_value, cell_row, cell_col
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gdds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gdds_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gdds_pkg::*;

  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int AW  = $clog2(3 * MAX_COLS);

  logic [CNW-1:0]   eff_cols;
  logic [RNW-1:0]   eff_rows;
  logic [VAL_W-1:0] inv_h_sq;
  logic [VAL_W-1:0] inv_four_h_sq;
  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;

  gdds_cfg #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .eff_cols      (eff_cols),
    .eff_rows      (eff_rows),
    .inv_h_sq      (inv_h_sq),
    .inv_four_h_sq (inv_four_h_sq)
  );

  gdds_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .eff_cols  (eff_cols),
    .eff_rows  (eff_rows),
    .cmd       (cmd),
    .status    (status),
    .ram_waddr (ram_waddr),
    .ram_raddr (ram_raddr)
  );

  gdds_dp #(
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .ram_waddr     (ram_waddr),
    .ram_raddr     (ram_raddr),
    .s_tdata       (s_tdata),
    .inv_h_sq      (inv_h_sq),
    .inv_four_h_sq (inv_four_h_sq),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast)
  );

endmodule

// ===== rtl/gdds_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module gdds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gdds_cfg.sv =====
// configuration registers and clamped grid size
`timescale 1ns / 1ps
module gdds_cfg #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 1024,
  localparam int CNW = $clog2(MAX_COLS + 1),
  localparam int RNW = $clog2(MAX_ROWS + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gdds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gdds_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [CNW-1:0]                      eff_cols,
  output logic [RNW-1:0]                      eff_rows,
  output logic [gdds_pkg::VAL_W-1:0]          inv_h_sq,
  output logic [gdds_pkg::VAL_W-1:0]          inv_four_h_sq
);
  import gdds_pkg::*;

  logic [COLS_W-1:0] grid_cols;
  logic [ROWS_W-1:0] grid_rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols     <= COLS_W'(256);
      grid_rows     <= ROWS_W'(256);
      inv_h_sq      <= VAL_W'(256);
      inv_four_h_sq <= VAL_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_COLS:     grid_cols     <= cfg_data[COLS_W-1:0];
        CFG_GRID_ROWS:     grid_rows     <= cfg_data[ROWS_W-1:0];
        CFG_INV_H_SQ:      inv_h_sq      <= cfg_data;
        CFG_INV_FOUR_H_SQ: inv_four_h_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(grid_cols) > MAX_COLS) begin
      eff_cols = CNW'(MAX_COLS);
    end else if (grid_cols < COLS_W'(2)) begin
      eff_cols = CNW'(2);
    end else begin
      eff_cols = CNW'(grid_cols);
    end
    if (32'(grid_rows) > MAX_ROWS) begin
      eff_rows = RNW'(MAX_ROWS);
    end else if (grid_rows < ROWS_W'(2)) begin
      eff_rows = RNW'(2);
    end else begin
      eff_rows = RNW'(grid_rows);
    end
  end

endmodule

// ===== rtl/gdds_ctrl.sv =====
// raster position, result sequencing and row store addressing
`timescale 1ns / 1ps
module gdds_ctrl #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 1024,
  localparam int CW  = $clog2(MAX_COLS),
  localparam int RW  = $clog2(MAX_ROWS),
  localparam int CNW = $clog2(MAX_COLS + 1),
  localparam int RNW = $clog2(MAX_ROWS + 1),
  localparam int AW  = $clog2(3 * MAX_COLS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [CNW-1:0]        eff_cols,
  input  logic [RNW-1:0]        eff_rows,
  output gdds_pkg::dp_cmd_t     cmd,
  input  gdds_pkg::dp_status_t  status,
  output logic [AW-1:0]         ram_waddr,
  output logic [AW-1:0]         ram_raddr
);
  import gdds_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_ST1   = 3'd3;
  localparam logic [2:0] S_ST2   = 3'd4;
  localparam logic [2:0] S_ST3   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [1:0] JOB_UP   = 2'd0;
  localparam logic [1:0] JOB_LEFT = 2'd1;
  localparam logic [1:0] JOB_SELF = 2'd2;

  function automatic logic [1:0] slot_prev(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [1:0] slot_succ(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [AW-1:0] slot_base(input logic [1:0] s);
    logic [AW-1:0] b;
    unique case (s)
      2'd0:    b = '0;
      2'd1:    b = AW'(MAX_COLS);
      2'd2:    b = AW'(2 * MAX_COLS);
      default: b = '0;
    endcase
    return b;
  endfunction

  logic [2:0]    state, state_next;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count;
  logic [1:0]    slot_count;
  logic [RW-1:0] item_r;
  logic [CW-1:0] item_c;
  logic [1:0]    item_slot;
  logic          has_b, has_c;
  logic [1:0]    job;
  logic [2:0]    tap;
  logic          cap_en_q;
  logic [2:0]    cap_tap_q;

  logic          accept, restart, last_col, last_row, more;
  logic [RW-1:0] pr, ci;
  logic [CW-1:0] pc, cj, lf, rt, rd_col;
  logic [1:0]    ps, su, si, sd, rd_slot;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign restart  = (RNW'(row_count) >= eff_rows) || (CNW'(col_count) >= eff_cols);
  assign pr       = restart ? '0 : row_count;
  assign pc       = restart ? '0 : col_count;
  assign ps       = restart ? 2'd0 : slot_count;
  assign last_col = (CNW'(pc) == eff_cols - CNW'(1));
  assign last_row = (RNW'(pr) == eff_rows - RNW'(1));
  assign more     = ((job == JOB_UP) && has_b) || ((job == JOB_LEFT) && has_c);

  always_comb begin
    unique case (job)
      JOB_UP: begin
        ci = item_r - RW'(1);
        cj = item_c;
        si = slot_prev(item_slot);
        sd = item_slot;
        su = (item_r > RW'(1)) ? slot_prev(slot_prev(item_slot)) : slot_prev(item_slot);
      end
      JOB_LEFT: begin
        ci = item_r;
        cj = item_c - CW'(1);
        su = slot_prev(item_slot);
        si = item_slot;
        sd = item_slot;
      end
      default: begin
        ci = item_r;
        cj = item_c;
        su = slot_prev(item_slot);
        si = item_slot;
        sd = item_slot;
      end
    endcase
  end

  assign lf = (cj == '0) ? cj : cj - CW'(1);
  assign rt = (CNW'(cj) == eff_cols - CNW'(1)) ? cj : cj + CW'(1);

  always_comb begin
    unique case (tap)
      TAP_UP: begin
        rd_slot = su;
        rd_col  = cj;
      end
      TAP_DN: begin
        rd_slot = sd;
        rd_col  = cj;
      end
      TAP_LF: begin
        rd_slot = si;
        rd_col  = lf;
      end
      TAP_RT: begin
        rd_slot = si;
        rd_col  = rt;
      end
      default: begin
        rd_slot = si;
        rd_col  = cj;
      end
    endcase
  end

  assign ram_raddr = slot_base(rd_slot) + AW'(rd_col);
  assign ram_waddr = slot_base(ps) + AW'(pc);

  always_comb begin
    cmd.ram_we    = accept;
    cmd.ram_re    = (state == S_READ);
    cmd.cap_en    = cap_en_q;
    cmd.cap_tap   = cap_tap_q;
    cmd.st1_en    = (state == S_ST1);
    cmd.st2_en    = (state == S_ST2);
    cmd.st3_en    = (state == S_ST3);
    cmd.out_load  = (state == S_OUT) && status.out_free;
    cmd.cell_row  = ROW_W'(ci);
    cmd.cell_col  = COL_W'(cj);
    cmd.cell_last = (job == JOB_SELF);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (pr != '0)) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (tap == TAP_MID) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_ST1;
      S_ST1:   state_next = S_ST2;
      S_ST2:   state_next = S_ST3;
      S_ST3:   state_next = S_OUT;
      S_OUT: begin
        if (status.out_free) begin
          state_next = more ? S_READ : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      row_count  <= '0;
      col_count  <= '0;
      slot_count <= 2'd0;
      job        <= JOB_UP;
      tap        <= TAP_UP;
      cap_en_q   <= 1'b0;
      cap_tap_q  <= TAP_UP;
    end else begin
      state     <= state_next;
      cap_en_q  <= (state == S_READ);
      cap_tap_q <= tap;
      if (accept) begin
        job <= JOB_UP;
        tap <= TAP_UP;
        if (last_col) begin
          col_count <= '0;
          if (last_row) begin
            row_count  <= '0;
            slot_count <= 2'd0;
          end else begin
            row_count  <= pr + RW'(1);
            slot_count <= slot_succ(ps);
          end
        end else begin
          col_count  <= pc + CW'(1);
          row_count  <= pr;
          slot_count <= ps;
        end
      end
      if ((state == S_READ) && (tap != TAP_MID)) begin
        tap <= tap + 3'd1;
      end
      if (cmd.out_load && more) begin
        job <= (job == JOB_UP) ? JOB_LEFT : JOB_SELF;
        tap <= TAP_UP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r    <= pr;
      item_c    <= pc;
      item_slot <= ps;
      has_b     <= last_row && (pc != '0);
      has_c     <= last_row && last_col;
    end
  end

  a_cap_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.cap_en |-> $past(state) == S_READ)
    else $error("tap capture without a preceding read");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !status.out_free) |=> (state == S_OUT && $stable(job)))
    else $error("result stage left while output occupied");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.ram_we |-> !cmd.ram_re)
    else $error("row store written during a read sequence");

  a_frame_end_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.cell_last) |=> state == S_IDLE)
    else $error("sequence continued after final cell");

endmodule

// ===== rtl/gdds_dp.sv =====
// row store, stencil arithmetic and output register
`timescale 1ns / 1ps
module gdds_dp #(
  parameter int MAX_COLS = 256,
  localparam int AW = $clog2(3 * MAX_COLS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gdds_pkg::dp_cmd_t             cmd,
  output gdds_pkg::dp_status_t          status,
  input  logic [AW-1:0]                 ram_waddr,
  input  logic [AW-1:0]                 ram_raddr,
  input  logic [gdds_pkg::IN_W-1:0]     s_tdata,
  input  logic [gdds_pkg::VAL_W-1:0]    inv_h_sq,
  input  logic [gdds_pkg::VAL_W-1:0]    inv_four_h_sq,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [gdds_pkg::OUT_W-1:0]    m_tdata,
  output logic                          m_tlast
);
  import gdds_pkg::*;

  localparam logic signed [52:0] SAT_MAX = 53'sd2147483647;
  localparam logic signed [52:0] SAT_MIN = -53'sd2147483648;

  logic [IN_W-1:0]          rdata;
  logic signed [VAL_W-1:0]  x_tap [TAP_N];
  logic signed [VAL_W-1:0]  y_tap [TAP_N];

  logic signed [18:0]       lap;
  logic signed [33:0]       pa, pb;
  logic signed [VAL_W-1:0]  xc1, xc2;
  logic signed [35:0]       p1;
  logic signed [34:0]       g;
  logic signed [51:0]       t1, t2;

  logic signed [16:0]       gxx, gxy, gyx, gyy;
  logic signed [16:0]       inv_h_s, inv_q_s;
  logic signed [52:0]       s_sum, q;
  logic [RES_W-1:0]         res_sat;

  logic [RES_W-1:0]         out_res;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         out_col;

  gdds_ram #(
    .WIDTH (IN_W),
    .DEPTH (3 * MAX_COLS)
  ) u_rows (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata),
    .re    (cmd.ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign gxx     = 17'(x_tap[TAP_RT]) - 17'(x_tap[TAP_LF]);
  assign gxy     = 17'(y_tap[TAP_RT]) - 17'(y_tap[TAP_LF]);
  assign gyx     = 17'(x_tap[TAP_DN]) - 17'(x_tap[TAP_UP]);
  assign gyy     = 17'(y_tap[TAP_DN]) - 17'(y_tap[TAP_UP]);
  assign inv_h_s = $signed({1'b0, inv_h_sq});
  assign inv_q_s = $signed({1'b0, inv_four_h_sq});

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      x_tap[cmd.cap_tap] <= rdata[VAL_W-1:0];
      y_tap[cmd.cap_tap] <= rdata[IN_W-1:VAL_W];
    end
    if (cmd.st1_en) begin
      lap <= 19'(y_tap[TAP_UP]) + 19'(y_tap[TAP_DN]) + 19'(y_tap[TAP_LF])
           + 19'(y_tap[TAP_RT]) - (19'(y_tap[TAP_MID]) <<< 2);
      pa  <= gxx * gxy;
      pb  <= gyx * gyy;
      xc1 <= x_tap[TAP_MID];
    end
    if (cmd.st2_en) begin
      p1  <= lap * inv_h_s;
      g   <= 35'(pa) + 35'(pb);
      xc2 <= xc1;
    end
    if (cmd.st3_en) begin
      t1 <= p1 * xc2;
      t2 <= g * inv_q_s;
    end
  end

  // round to q16.16 (floor after half-lsb offset), then saturate
  assign s_sum = 53'(t1) + 53'(t2) + 53'sd128;
  assign q     = s_sum >>> 8;

  always_comb begin
    if (q > SAT_MAX) begin
      res_sat = 32'h7FFF_FFFF;
    end else if (q < SAT_MIN) begin
      res_sat = 32'h8000_0000;
    end else begin
      res_sat = q[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res <= res_sat;
      out_row <= cmd.cell_row;
      out_col <= cmd.cell_col;
      m_tlast <= cmd.cell_last;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_col, out_row, out_res};

  assign status.out_free  = !m_tvalid || m_tready;

endmodule

// ===== tb/grid_drift_diffusion_stencil_core_tb.sv =====
// self-checking testbench: streams grid samples, predicts every stencil result and compares
`timescale 1ns / 1ps
module grid_drift_diffusion_stencil_core_tb;
  import gdds_pkg::*;

  localparam int GRID_MAX_COLS = 256;
  localparam int GRID_MAX_ROWS = 1024;
  localparam int MAX_IDLE      = 13;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_WORDS  = 64;
  localparam int MAX_REPORTS   = 40;
  localparam longint SAT_MAX   = 64'sd2147483647;
  localparam longint SAT_MIN   = -64'sd2147483648;

  typedef struct packed {
    logic [RES_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } cell_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;   // x_value, y_value
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;   // result_value, cell_row, cell_col, zero pad
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // mirror of the block: config, position and row store
  logic [COLS_W-1:0]     grid_cols_q;
  logic [ROWS_W-1:0]     grid_rows_q;
  logic [15:0]           inv_h_sq_q;
  logic [15:0]           inv_four_h_sq_q;
  int                    grid_row;
  int                    grid_col;
  logic signed [15:0]    coef_store  [0:3*GRID_MAX_COLS-1];
  logic signed [15:0]    field_store [0:3*GRID_MAX_COLS-1];

  cell_result_t          expected_cells [$];

  bit tx_idle_on;
  bit rx_idle_on;
  int words_sent;
  int results_seen;
  int reg_writes;
  int random_frames;
  int random_words;
  int mismatches;

  grid_drift_diffusion_stencil_core #(
    .MAX_COLS(GRID_MAX_COLS),
    .MAX_ROWS(GRID_MAX_ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int cols_in_use();
    int n;
    n = grid_cols_q;
    if (n > GRID_MAX_COLS) n = GRID_MAX_COLS;
    if (n < 2) n = 2;
    return n;
  endfunction

  function automatic int rows_in_use();
    int n;
    n = grid_rows_q;
    if (n > GRID_MAX_ROWS) n = GRID_MAX_ROWS;
    if (n < 2) n = 2;
    return n;
  endfunction

  function automatic longint coef_at(input int row, input int col);
    return longint'(coef_store[(row % 3) * GRID_MAX_COLS + col]);
  endfunction

  function automatic longint field_at(input int row, input int col);
    return longint'(field_store[(row % 3) * GRID_MAX_COLS + col]);
  endfunction

  function automatic logic [RES_W-1:0] drift_diffusion_at(input int i, input int j);
    int rows_n, cols_n, up, dn, lf, rt;
    longint lap, t1, t2, s, q;
    rows_n = rows_in_use();
    cols_n = cols_in_use();
    up = (i > 0) ? i - 1 : 0;
    dn = (i + 1 < rows_n) ? i + 1 : rows_n - 1;
    lf = (j > 0) ? j - 1 : 0;
    rt = (j + 1 < cols_n) ? j + 1 : cols_n - 1;
    lap = field_at(up, j) + field_at(dn, j) + field_at(i, lf) + field_at(i, rt)
          - 4 * field_at(i, j);
    t1 = lap * longint'(inv_h_sq_q) * coef_at(i, j);
    t2 = ((coef_at(i, rt) - coef_at(i, lf)) * (field_at(i, rt) - field_at(i, lf))
          + (coef_at(dn, j) - coef_at(up, j)) * (field_at(dn, j) - field_at(up, j)))
         * longint'(inv_four_h_sq_q);
    // round to q16.16 by flooring after adding half an lsb, then saturate
    s = t1 + t2 + 128;
    q = s >>> 8;
    if (q > SAT_MAX) q = SAT_MAX;
    if (q < SAT_MIN) q = SAT_MIN;
    return q[RES_W-1:0];
  endfunction

  task automatic push_cell(input int i, input int j);
    cell_result_t exp_item;
    exp_item.value = drift_diffusion_at(i, j);
    exp_item.row   = ROW_W'(i);
    exp_item.col   = COL_W'(j);
    exp_item.last  = (i == rows_in_use() - 1) && (j == cols_in_use() - 1);
    expected_cells = {expected_cells, exp_item};
  endtask

  task automatic absorb_sample(input logic [15:0] x, input logic [15:0] y);
    int rows_n, cols_n, r, c;
    rows_n = rows_in_use();
    cols_n = cols_in_use();
    if (grid_row >= rows_n || grid_col >= cols_n) begin
      grid_row = 0;
      grid_col = 0;
    end
    r = grid_row;
    c = grid_col;
    coef_store[(r % 3) * GRID_MAX_COLS + c]  = x;
    field_store[(r % 3) * GRID_MAX_COLS + c] = y;
    if (r >= 1) begin
      push_cell(r - 1, c);
      // last row flushes its own cells as it streams in
      if (r == rows_n - 1) begin
        if (c >= 1) push_cell(r, c - 1);
        if (c == cols_n - 1) push_cell(r, c);
      end
    end
    grid_col = c + 1;
    if (grid_col >= cols_n) begin
      grid_col = 0;
      grid_row = r + 1;
      if (grid_row >= rows_n) grid_row = 0;
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch %0d: %s", mismatches, what);
  endtask

  function automatic logic [15:0] random_sample(input int shift);
    logic signed [15:0] v;
    v = 16'($urandom);
    return v >>> shift;
  endfunction

  function automatic logic [15:0] random_scale();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    if (sel == 2) return 16'($urandom_range(1, 512));
    return 16'($urandom);
  endfunction

  task automatic send_word(input logic [15:0] x, input logic [15:0] y);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    do @(posedge clk); while (!s_tready);
    absorb_sample(x, y);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results(input int quiet_cycles);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (expected_cells.size() != 0);
    repeat (quiet_cycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GRID_COLS:     grid_cols_q     = data[COLS_W-1:0];
      CFG_GRID_ROWS:     grid_rows_q     = data[ROWS_W-1:0];
      CFG_INV_H_SQ:      inv_h_sq_q      = data;
      CFG_INV_FOUR_H_SQ: inv_four_h_sq_q = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic program_grid(input logic [15:0] cols_word, input logic [15:0] rows_word,
                              input logic [15:0] h_scale, input logic [15:0] grad_scale);
    wait_results(SETTLE_CYCLES);
    write_reg(CFG_INV_H_SQ, h_scale);
    write_reg(CFG_GRID_COLS, cols_word);
    write_reg(CFG_INV_FOUR_H_SQ, grad_scale);
    write_reg(CFG_GRID_ROWS, rows_word);
    cfg_valid <= 1'b0;
  endtask

  // default scaling, first row silent, restart when the new width excludes the position
  task automatic test_reset_defaults();
    repeat (3) send_word(random_sample(0), random_sample(0));
    wait_results(SETTLE_CYCLES);
    write_reg(CFG_GRID_COLS, 16'd2);
    write_reg(CFG_GRID_ROWS, 16'd2);
    cfg_valid <= 1'b0;
    send_word(16'h7FFF, 16'h8000);
    send_word(16'h8000, 16'h7FFF);
    send_word(16'h0000, 16'hFFFF);
    send_word(16'hFFFF, 16'h0001);
  endtask

  // full-scale samples with maximum scaling drive saturation both ways
  task automatic test_extreme_values();
    logic [15:0] xs [0:8];
    logic [15:0] ys [0:8];
    xs = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
           16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
    ys = '{16'h0000, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h8000,
           16'h7FFF, 16'h0001, 16'h7FFF, 16'h0000};
    program_grid(16'd3, 16'd3, 16'hFFFF, 16'hFFFF);
    for (int k = 0; k < 9; k++) send_word(xs[k], ys[k]);
    program_grid(16'd2, 16'd2, 16'hFFFF, 16'hFFFF);
    send_word(16'h8000, 16'h8000);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h0000, 16'h7FFF);
    send_word(16'hFFFF, 16'h8000);
  endtask

  // sizes below the minimum clamp to two, upper config bits are dropped, zero scaling
  task automatic test_clamped_sizes();
    program_grid(16'hFE00, 16'hF801, 16'h0000, 16'h0000);
    repeat (4) send_word(random_sample(0), random_sample(0));
  endtask

  // shrink and grow the grid with the position still inside it
  task automatic test_resize_mid_frame();
    logic [15:0] hs, gs;
    hs = 16'($urandom_range(1, 1024));
    gs = 16'($urandom_range(1, 1024));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    program_grid(16'd6, 16'd6, hs, gs);
    repeat (8) send_word(random_sample(6), random_sample(4));
    program_grid(16'd4, 16'd3, hs, gs);
    repeat (6) send_word(random_sample(6), random_sample(4));
    program_grid(16'd3, 16'd2, hs, gs);
    repeat (4) send_word(random_sample(5), random_sample(5));
    program_grid(16'd3, 16'd4, hs, gs);
    repeat (7) send_word(random_sample(5), random_sample(5));
  endtask

  // tallest grid, abandoned part way down by a height that forces a restart
  task automatic test_tallest_grid();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    program_grid(16'd2, 16'h0400, random_scale(), random_scale());
    repeat (20) send_word(random_sample(3), random_sample(3));
    program_grid(16'd2, 16'd5, random_scale(), random_scale());
    repeat (10) send_word(random_sample(2), random_sample(7));
  endtask

  // widest grid through a masked width, cut short by a narrower one; sender drains once
  task automatic test_widest_grid();
    tx_idle_on = $urandom_range(0, 1);
    rx_idle_on = $urandom_range(0, 1);
    program_grid(16'hFFFF, 16'd2, random_scale(), random_scale());
    for (int k = 0; k < GRID_MAX_COLS + 8; k++) begin
      if (k == 200) wait_results(0);
      send_word(random_sample(k % 9), random_sample((k / 7) % 12));
    end
    program_grid(16'd4, 16'd2, random_scale(), random_scale());
    repeat (8) send_word(random_sample(4), random_sample(4));
  endtask

  // random sizes, scales and content; some frames are cut short and restarted
  task automatic test_random_frames();
    int cols_val, rows_val, cols_n, rows_n, n, pause_at, amp_x, amp_y, sel;
    bit broken;
    while (random_words < RANDOM_WORDS) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) cols_val = $urandom_range(0, 1);
      else if (sel <= 2) cols_val = $urandom_range(11, 24);
      else cols_val = $urandom_range(2, 10);
      sel = $urandom_range(0, 19);
      if (sel == 0) rows_val = $urandom_range(0, 1);
      else if (sel <= 2) rows_val = $urandom_range(9, 12);
      else rows_val = $urandom_range(2, 8);
      // after a cut-short frame the new height must exclude the position
      if (grid_row != 0 || grid_col != 0) rows_val = $urandom_range(2, grid_row);
      program_grid({7'($urandom), 9'(cols_val)}, {5'($urandom), 11'(rows_val)},
                   random_scale(), random_scale());
      cols_n = cols_in_use();
      rows_n = rows_in_use();
      broken = (rows_n >= 3) && ($urandom_range(0, 4) == 0);
      n = broken ? 2 * cols_n + $urandom_range(0, (rows_n - 2) * cols_n - 1)
                 : rows_n * cols_n;
      pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : -1;
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      amp_x = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      amp_y = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      for (int k = 0; k < n; k++) begin
        if (k == pause_at) wait_results(0);
        send_word(random_sample(amp_x), random_sample(amp_y));
        random_words++;
      end
      random_frames++;
    end
  endtask

  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_cells.size() == 0) begin
        report_mismatch($sformatf("unexpected word row %0d col %0d",
                                  m_tdata[RES_W +: ROW_W], m_tdata[RES_W + ROW_W +: COL_W]));
      end else begin
        want = expected_cells.pop_front();
        if (m_tdata[RES_W-1:0] !== want.value)
          report_mismatch($sformatf("cell (%0d,%0d) value %0d, expected %0d", want.row,
                                    want.col, $signed(m_tdata[RES_W-1:0]), $signed(want.value)));
        if (m_tdata[RES_W +: ROW_W] !== want.row)
          report_mismatch($sformatf("row %0d, expected %0d", m_tdata[RES_W +: ROW_W], want.row));
        if (m_tdata[RES_W + ROW_W +: COL_W] !== want.col)
          report_mismatch($sformatf("col %0d, expected %0d",
                                    m_tdata[RES_W + ROW_W +: COL_W], want.col));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("cell (%0d,%0d) tlast %0b, expected %0b",
                                    want.row, want.col, m_tlast, want.last));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, expected_cells.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_GRID_COLS;
    cfg_data   = '0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    grid_cols_q     = COLS_W'(256);
    grid_rows_q     = ROWS_W'(256);
    inv_h_sq_q      = 16'd256;
    inv_four_h_sq_q = 16'd64;
    grid_row = 0;
    grid_col = 0;
    for (int k = 0; k < 3 * GRID_MAX_COLS; k++) begin
      coef_store[k]  = '0;
      field_store[k] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_extreme_values();
    test_clamped_sizes();
    test_resize_mid_frame();
    test_tallest_grid();
    test_widest_grid();
    test_random_frames();
    wait_results(SETTLE_CYCLES);

    $display("sent %0d words, checked %0d results, %0d register writes, %0d random frames",
             words_sent, results_seen, reg_writes, random_frames);
    $display("covered saturation, clamped and masked sizes, resizes and restarts mid frame");
    if (mismatches == 0 && expected_cells.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gdds_pkg.sv
rtl/gdds_ram.sv
rtl/gdds_cfg.sv
rtl/gdds_ctrl.sv
rtl/gdds_dp.sv
rtl/grid_drift_diffusion_stencil_core.sv
tb/grid_drift_diffusion_stencil_core_tb.sv
